// ===== design/sbmq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types, sizes and helpers for the shared-buffer multi-queue block.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  // pool and queue sizing
  localparam int SLOT_COUNT  = 256;
  localparam int QUEUE_COUNT = 8;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W       = SLOT_W + 1;
  localparam int QID_W       = 3;
  localparam int DATA_W      = 32;

  // null pointer: anything at or above SLOT_COUNT
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOT_COUNT);

  // command queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_W     = $clog2(FQ_DEPTH);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic [QID_W-1:0]         qid;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     pool_full;
    logic                     queue_empty;
  } res_t;

  function automatic logic is_nil(input logic [PTR_W-1:0] ptr);
    return ptr >= NIL_PTR;
  endfunction

endpackage

// ===== design/sbmq_front.sv =====
// ----------------------------------------------------------------------------
// sbmq_front
// Takes commands, decodes the operation and holds them in a short queue
// until the back end is ready for them.
// ----------------------------------------------------------------------------
module sbmq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic                              in_mode,
  input  logic [sbmq_pkg::QID_W-1:0]        in_queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_value,
  output logic                              full,
  output logic                              item_valid,
  output sbmq_pkg::item_t                   item,
  input  logic                              pop
);

  sbmq_pkg::item_t             fq_mem [sbmq_pkg::FQ_DEPTH];
  logic [sbmq_pkg::FQ_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sbmq_pkg::FQ_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sbmq_pkg::FQ_W:0]     count_r, count_nxt;
  sbmq_pkg::item_t             dec_item;

  // decode the incoming transfer
  always_comb begin
    dec_item.op    = in_mode ? sbmq_pkg::OP_DEQ : sbmq_pkg::OP_ENQ;
    dec_item.qid   = in_queue_id;
    dec_item.value = in_value;
  end

  assign full       = (count_r == (sbmq_pkg::FQ_W+1)'(sbmq_pkg::FQ_DEPTH));
  assign item_valid = (count_r != '0);
  assign item       = fq_mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sbmq_pkg::FQ_W'(sbmq_pkg::FQ_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbmq_pkg::FQ_W'(sbmq_pkg::FQ_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fq_mem[wr_ptr_r] <= dec_item;
    end
  end

endmodule

// ===== design/sbmq_back.sv =====
// ----------------------------------------------------------------------------
// sbmq_back
// Executes queued commands against the slot pool: link and data memories,
// per-queue head and tail pointers and the free chain. Runs the link
// initialization walk after reset.
// ----------------------------------------------------------------------------
module sbmq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  sbmq_pkg::item_t item,
  output logic            pop,
  output logic            init_busy,
  output logic            res_valid,
  output sbmq_pkg::res_t  res
);

  typedef enum logic [1:0] {
    S_INIT,
    S_EXEC,
    S_FIN
  } state_t;

  // memories
  logic [sbmq_pkg::PTR_W-1:0]  link_mem [sbmq_pkg::SLOT_COUNT];
  logic [sbmq_pkg::DATA_W-1:0] data_mem [sbmq_pkg::SLOT_COUNT];

  state_t                      state_r, state_nxt;
  logic [sbmq_pkg::SLOT_W-1:0] init_idx_r, init_idx_nxt;
  logic [sbmq_pkg::PTR_W-1:0]  head_r [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  head_nxt [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  tail_r [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  tail_nxt [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  free_head_r, free_head_nxt;
  logic [sbmq_pkg::SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [sbmq_pkg::QID_W-1:0]  cur_q_r, cur_q_nxt;
  sbmq_pkg::op_t               cur_op_r, cur_op_nxt;
  logic                        res_valid_r, res_valid_nxt;
  sbmq_pkg::res_t              res_r, res_nxt;

  logic                        link_we;
  logic [sbmq_pkg::SLOT_W-1:0] link_waddr;
  logic [sbmq_pkg::PTR_W-1:0]  link_wdata;
  logic [sbmq_pkg::SLOT_W-1:0] link_raddr;
  logic [sbmq_pkg::PTR_W-1:0]  link_rd_r;
  logic                        data_we;
  logic [sbmq_pkg::SLOT_W-1:0] data_raddr;
  logic [sbmq_pkg::DATA_W-1:0] data_rd_r;

  assign init_busy = (state_r == S_INIT);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // link initialization walk, then command sequencing: issue cycle, then finish cycle with read data unless rejected
  always_comb begin
    logic [sbmq_pkg::QID_W-1:0]  q;
    logic [sbmq_pkg::PTR_W-1:0]  nx;
    q             = item.qid;
    nx            = link_rd_r;
    state_nxt     = state_r;
    init_idx_nxt  = init_idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    cur_slot_nxt  = cur_slot_r;
    cur_q_nxt     = cur_q_r;
    cur_op_nxt    = cur_op_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    pop           = 1'b0;
    link_we       = 1'b0;
    link_waddr    = cur_slot_r;
    link_wdata    = sbmq_pkg::NIL_PTR;
    link_raddr    = cur_slot_r;
    data_we       = 1'b0;
    data_raddr    = cur_slot_r;
    case (state_r)
      S_INIT: begin
        // entry i links to i+1, the last one to null
        link_we      = 1'b1;
        link_waddr   = init_idx_r;
        link_wdata   = {1'b0, init_idx_r} + 1'b1;
        init_idx_nxt = init_idx_r + 1'b1;
        if (init_idx_r == sbmq_pkg::SLOT_W'(sbmq_pkg::SLOT_COUNT-1)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_valid) begin
          pop        = 1'b1;
          cur_q_nxt  = q;
          cur_op_nxt = item.op;
          if (item.op == sbmq_pkg::OP_ENQ) begin
            if (sbmq_pkg::is_nil(free_head_r)) begin
              // pool full: reject at once
              res_valid_nxt       = 1'b1;
              res_nxt.status      = sbmq_pkg::ST_FULL;
              res_nxt.data        = '0;
              res_nxt.pool_full   = 1'b1;
              res_nxt.queue_empty = sbmq_pkg::is_nil(head_r[q]);
            end else begin
              // take the free head, link it after the tail (or make it the head), fetch its link
              cur_slot_nxt = free_head_r[sbmq_pkg::SLOT_W-1:0];
              link_raddr   = free_head_r[sbmq_pkg::SLOT_W-1:0];
              if (sbmq_pkg::is_nil(head_r[q])) begin
                head_nxt[q] = free_head_r;
              end else if (!sbmq_pkg::is_nil(tail_r[q])) begin
                link_we    = 1'b1;
                link_waddr = tail_r[q][sbmq_pkg::SLOT_W-1:0];
                link_wdata = free_head_r;
              end
              tail_nxt[q] = free_head_r;
              data_we     = 1'b1;
              state_nxt   = S_FIN;
            end
          end else begin
            if (sbmq_pkg::is_nil(head_r[q])) begin
              // empty queue: reject at once
              res_valid_nxt       = 1'b1;
              res_nxt.status      = sbmq_pkg::ST_EMPTY;
              res_nxt.data        = '0;
              res_nxt.pool_full   = sbmq_pkg::is_nil(free_head_r);
              res_nxt.queue_empty = 1'b1;
            end else begin
              // fetch link and data of the head slot
              cur_slot_nxt = head_r[q][sbmq_pkg::SLOT_W-1:0];
              link_raddr   = head_r[q][sbmq_pkg::SLOT_W-1:0];
              data_raddr   = head_r[q][sbmq_pkg::SLOT_W-1:0];
              state_nxt    = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        res_valid_nxt  = 1'b1;
        res_nxt.status = sbmq_pkg::ST_DONE;
        link_we        = 1'b1;
        link_waddr     = cur_slot_r;
        state_nxt      = S_EXEC;
        if (cur_op_r == sbmq_pkg::OP_ENQ) begin
          // free chain advances; new tail links to null
          free_head_nxt       = link_rd_r;
          link_wdata          = sbmq_pkg::NIL_PTR;
          res_nxt.data        = '0;
          res_nxt.pool_full   = sbmq_pkg::is_nil(link_rd_r);
          res_nxt.queue_empty = 1'b0;
        end else begin
          // unlink head, push the slot onto the free chain
          if (sbmq_pkg::is_nil(nx)) begin
            head_nxt[cur_q_r] = sbmq_pkg::NIL_PTR;
            tail_nxt[cur_q_r] = sbmq_pkg::NIL_PTR;
          end else begin
            head_nxt[cur_q_r] = nx;
          end
          link_wdata          = free_head_r;
          free_head_nxt       = {1'b0, cur_slot_r};
          res_nxt.data        = data_rd_r;
          res_nxt.pool_full   = 1'b0;
          res_nxt.queue_empty = sbmq_pkg::is_nil(nx);
        end
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      free_head_r <= '0;
      res_valid_r <= 1'b0;
      res_r       <= '0;
      for (int i = 0; i < sbmq_pkg::QUEUE_COUNT; i++) begin
        head_r[i] <= sbmq_pkg::NIL_PTR;
        tail_r[i] <= sbmq_pkg::NIL_PTR;
      end
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      free_head_r <= free_head_nxt;
      res_valid_r <= res_valid_nxt;
      res_r       <= res_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  // per-command payload
  always_ff @(posedge clk) begin
    cur_slot_r <= cur_slot_nxt;
    cur_q_r    <= cur_q_nxt;
    cur_op_r   <= cur_op_nxt;
  end

  // link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[link_raddr];
  end

  // data memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[cur_slot_nxt] <= item.value;
    end
    data_rd_r <= data_mem[data_raddr];
  end

  // no command is taken during the link walk
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !pop)
    else $error("command popped during link initialization");

  // every finish cycle delivers a done result
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (res_valid_r && res_r.status == sbmq_pkg::ST_DONE))
    else $error("finish cycle without a done result");

  // enqueue on an empty free chain is rejected with pool full
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && pop && item.op == sbmq_pkg::OP_ENQ
     && sbmq_pkg::is_nil(free_head_r))
    |=> (res_valid_r && res_r.status == sbmq_pkg::ST_FULL && res_r.pool_full))
    else $error("full pool enqueue not rejected");

  // free chain is untouched while the walk runs
  a_init_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (free_head_r == '0))
    else $error("free head moved during link initialization");

endmodule

// ===== design/shared_buffer_multi_queue.sv =====
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Eight FIFO queues sharing a 256-slot pool through linked lists and a
// free chain.
// ----------------------------------------------------------------------------
// Path: a done enqueue or dequeue result passes the command queue, issue state,
//   finish state and result register; a rejected one (pool full, queue empty)
//   skips the finish state. No command is taken while a done one is there, as
//   the link memory read must return before the free chain or queue head
//   can advance. Reset: synchronous, then a link initialization walk over all
//   256 slots runs with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic [sbmq_pkg::QID_W-1:0]         in_queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_value,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic signed [sbmq_pkg::DATA_W-1:0] out_data_out,
  output logic                               out_pool_full,
  output logic                               out_queue_empty
);

  logic            fq_full;
  logic            item_valid;
  sbmq_pkg::item_t item;
  logic            pop;
  logic            init_busy;
  logic            res_valid;
  sbmq_pkg::res_t  res;

  // a transfer is taken when start meets a free command queue and no link walk runs
  assign busy = fq_full | init_busy;

  sbmq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (start && !busy),
    .in_mode     (in_mode),
    .in_queue_id (in_queue_id),
    .in_value    (in_value),
    .full        (fq_full),
    .item_valid  (item_valid),
    .item        (item),
    .pop         (pop)
  );

  sbmq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .init_busy  (init_busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result ports
  assign out_strobe      = res_valid;
  assign out_status      = res.status;
  assign out_data_out    = res.data;
  assign out_pool_full   = res.pool_full;
  assign out_queue_empty = res.queue_empty;

endmodule

// ===== tb/shared_buffer_multi_queue_tb.sv =====
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_tb
// Self-checking bench for the eight-queue shared slot pool. Enqueue and
// dequeue commands go in through the start/busy handshake, and a local model
// of the linked lists and free chain predicts each result. Strobed results
// are checked in order. The run covers empty dequeues, data extremes on every
// queue, filling the pool to the point of rejection, draining it, and random
// traffic with bursty pacing.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // DUT ports
  logic                               clk         = 1'b0;
  logic                               rst_n       = 1'b0;
  logic                               start       = 1'b0;
  logic                               busy;
  logic                               in_mode     = 1'b0;
  logic [sbmq_pkg::QID_W-1:0]         in_queue_id = '0;
  logic signed [sbmq_pkg::DATA_W-1:0] in_value    = '0;
  logic                               out_strobe;
  logic [1:0]                         out_status;
  logic signed [sbmq_pkg::DATA_W-1:0] out_data_out;
  logic                               out_pool_full;
  logic                               out_queue_empty;

  shared_buffer_multi_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_queue_id     (in_queue_id),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_pool_full   (out_pool_full),
    .out_queue_empty (out_queue_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the pool: data and link stores, per-queue head/tail, free chain
  logic [sbmq_pkg::DATA_W-1:0] pool_data [sbmq_pkg::SLOT_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  pool_link [sbmq_pkg::SLOT_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  q_head    [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  q_tail    [sbmq_pkg::QUEUE_COUNT];
  logic [sbmq_pkg::PTR_W-1:0]  free_ptr;

  sbmq_pkg::res_t expected_results[$];

  int error_count    = 0;
  int results_seen   = 0;
  int transfers_sent = 0;
  int slots_in_use   = 0;
  int peak_in_use    = 0;
  int enq_done       = 0;
  int enq_rejected   = 0;
  int deq_done       = 0;
  int deq_on_empty   = 0;
  int burst_left     = 0;

  function automatic void pool_model_reset();
    for (int i = 0; i < sbmq_pkg::SLOT_COUNT; i++) begin
      pool_data[i] = '0;
      pool_link[i] = sbmq_pkg::PTR_W'(i + 1);
    end
    for (int i = 0; i < sbmq_pkg::QUEUE_COUNT; i++) begin
      q_head[i] = sbmq_pkg::NIL_PTR;
      q_tail[i] = sbmq_pkg::NIL_PTR;
    end
    free_ptr = '0;
  endfunction

  // apply one command to the model and return the result it should produce
  function automatic sbmq_pkg::res_t pool_model_step(
      input sbmq_pkg::op_t op, input logic [sbmq_pkg::QID_W-1:0] qid,
      input logic [sbmq_pkg::DATA_W-1:0] val);
    sbmq_pkg::res_t              r;
    logic [sbmq_pkg::SLOT_W-1:0] slot;
    logic [sbmq_pkg::PTR_W-1:0]  nxt;
    r.status      = sbmq_pkg::ST_DONE;
    r.data        = '0;
    r.pool_full   = 1'b0;
    r.queue_empty = 1'b0;
    if (op == sbmq_pkg::OP_ENQ) begin
      if (free_ptr >= sbmq_pkg::NIL_PTR) begin
        r.status = sbmq_pkg::ST_FULL;
        enq_rejected++;
      end else begin
        slot     = free_ptr[sbmq_pkg::SLOT_W-1:0];
        free_ptr = pool_link[slot];
        if (q_head[qid] >= sbmq_pkg::NIL_PTR)
          q_head[qid] = {1'b0, slot};
        else if (q_tail[qid] < sbmq_pkg::NIL_PTR)
          pool_link[q_tail[qid][sbmq_pkg::SLOT_W-1:0]] = {1'b0, slot};
        q_tail[qid]     = {1'b0, slot};
        pool_data[slot] = val;
        pool_link[slot] = sbmq_pkg::NIL_PTR;
        slots_in_use++;
        if (slots_in_use > peak_in_use) peak_in_use = slots_in_use;
        enq_done++;
      end
    end else begin
      if (q_head[qid] >= sbmq_pkg::NIL_PTR) begin
        r.status = sbmq_pkg::ST_EMPTY;
        deq_on_empty++;
      end else begin
        slot = q_head[qid][sbmq_pkg::SLOT_W-1:0];
        nxt  = pool_link[slot];
        if (nxt >= sbmq_pkg::NIL_PTR) begin
          q_head[qid] = sbmq_pkg::NIL_PTR;
          q_tail[qid] = sbmq_pkg::NIL_PTR;
        end else begin
          q_head[qid] = nxt;
        end
        pool_link[slot] = free_ptr;
        free_ptr        = {1'b0, slot};
        r.data          = pool_data[slot];
        slots_in_use--;
        deq_done++;
      end
    end
    r.pool_full   = (free_ptr >= sbmq_pkg::NIL_PTR);
    r.queue_empty = (q_head[qid] >= sbmq_pkg::NIL_PTR);
    return r;
  endfunction

  // mostly uniform words, with the corners mixed in
  function automatic logic [sbmq_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(15, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // a random queue that still holds entries
  function automatic int pick_busy_queue();
    int first;
    int q;
    first = $urandom_range(sbmq_pkg::QUEUE_COUNT - 1, 0);
    for (int k = 0; k < sbmq_pkg::QUEUE_COUNT; k++) begin
      q = (first + k) % sbmq_pkg::QUEUE_COUNT;
      if (q_head[q] < sbmq_pkg::NIL_PTR) return q;
    end
    return first;
  endfunction

  // one command transfer; start stays high afterwards for back-to-back items
  task automatic send_op(input sbmq_pkg::op_t op, input int qid,
                         input logic [sbmq_pkg::DATA_W-1:0] val);
    sbmq_pkg::res_t r;
    start       <= 1'b1;
    in_mode     <= op;
    in_queue_id <= sbmq_pkg::QID_W'(qid);
    in_value    <= val;
    do @(posedge clk); while (busy !== 1'b0);
    r = pool_model_step(op, sbmq_pkg::QID_W'(qid), val);
    expected_results.push_back(r);
    transfers_sent++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // bursts of random length separated by random gaps
  task automatic pace(input int max_gap);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if (max_gap > 0) hold_off($urandom_range(max_gap, 0));
    end
    burst_left--;
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_dequeue();
    send_op(sbmq_pkg::OP_DEQ, 0, 32'h0);
    send_op(sbmq_pkg::OP_DEQ, 7, 32'hFFFF_FFFF);
    send_op(sbmq_pkg::OP_DEQ, 5, $urandom);
  endtask

  // one corner value per queue, a second entry on the outer queues for order
  task automatic test_extreme_values();
    logic [sbmq_pkg::DATA_W-1:0] corners [sbmq_pkg::QUEUE_COUNT];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
    for (int q = 0; q < sbmq_pkg::QUEUE_COUNT; q++) send_op(sbmq_pkg::OP_ENQ, q, corners[q]);
    send_op(sbmq_pkg::OP_ENQ, 0, 32'h1234_5678);
    send_op(sbmq_pkg::OP_ENQ, 7, 32'hEDCB_A987);
    for (int q = 0; q < sbmq_pkg::QUEUE_COUNT; q++) send_op(sbmq_pkg::OP_DEQ, q, $urandom);
    send_op(sbmq_pkg::OP_DEQ, 0, $urandom);
    send_op(sbmq_pkg::OP_DEQ, 7, $urandom);
    send_op(sbmq_pkg::OP_DEQ, 0, $urandom);
  endtask

  // random mix; qspan narrows traffic onto a few queues to build deep chains
  task automatic run_traffic(input int count, input int enq_pct, input int max_gap,
                             input int qspan);
    int base;
    sbmq_pkg::op_t op;
    base = $urandom_range(sbmq_pkg::QUEUE_COUNT - 1, 0);
    for (int k = 0; k < count; k++) begin
      pace(max_gap);
      op = ($urandom_range(99, 0) < enq_pct) ? sbmq_pkg::OP_ENQ : sbmq_pkg::OP_DEQ;
      send_op(op, (base + $urandom_range(qspan - 1, 0)) % sbmq_pkg::QUEUE_COUNT,
              random_word());
    end
  endtask

  // fill every slot, bounce off the full pool, free and refill one slot, then drain it completely
  task automatic test_pool_full();
    while (slots_in_use < sbmq_pkg::SLOT_COUNT) begin
      pace(3);
      send_op(sbmq_pkg::OP_ENQ, $urandom_range(sbmq_pkg::QUEUE_COUNT - 1, 0), random_word());
    end
    for (int k = 0; k < 6; k++)
      send_op(sbmq_pkg::OP_ENQ, $urandom_range(sbmq_pkg::QUEUE_COUNT - 1, 0), $urandom);
    for (int q = 0; q < sbmq_pkg::QUEUE_COUNT; q++) begin
      if (q_head[q] < sbmq_pkg::NIL_PTR) begin
        send_op(sbmq_pkg::OP_DEQ, q, $urandom);
        break;
      end
    end
    send_op(sbmq_pkg::OP_ENQ, 3, $urandom);
    send_op(sbmq_pkg::OP_ENQ, 4, $urandom);
    wait_results_drained();
    while (slots_in_use > 0) begin
      pace(3);
      send_op(sbmq_pkg::OP_DEQ, pick_busy_queue(), $urandom);
    end
    for (int q = 0; q < sbmq_pkg::QUEUE_COUNT; q++) send_op(sbmq_pkg::OP_DEQ, q, $urandom);
  endtask

  task automatic test_random_traffic_a();
    run_traffic(200, 60, 4, sbmq_pkg::QUEUE_COUNT);
    run_traffic(150, 50, 0, sbmq_pkg::QUEUE_COUNT);
    run_traffic(200, 75, 3, 2);
  endtask

  task automatic test_random_traffic_b();
    run_traffic(200, 35, 6, sbmq_pkg::QUEUE_COUNT);
    run_traffic(200, 55, 2, 4);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    sbmq_pkg::res_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display({"ERROR %0t: result with nothing pending:",
                    " status=%0d data=%0h full=%b empty=%b"},
                   $time, out_status, out_data_out, out_pool_full, out_queue_empty);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (out_status !== want.status || out_data_out !== want.data ||
            out_pool_full !== want.pool_full || out_queue_empty !== want.queue_empty) begin
          error_count++;
          if (error_count <= 10)
            $display({"ERROR %0t: result %0d expected status=%0d data=%0h full=%b empty=%b,",
                      " got status=%0d data=%0h full=%b empty=%b"},
                     $time, results_seen, want.status, want.data, want.pool_full,
                     want.queue_empty, out_status, out_data_out, out_pool_full,
                     out_queue_empty);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    pool_model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_dequeue();
    test_extreme_values();
    test_random_traffic_a();
    wait_results_drained();
    test_pool_full();
    wait_results_drained();
    test_random_traffic_b();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      $display("ERROR: %0d results never arrived", expected_results.size());
    end

    $display({"Ran %0d commands, %0d results checked: %0d enqueues stored,",
              " %0d rejected on full pool,"},
             transfers_sent, results_seen, enq_done, enq_rejected);
    $display("%0d dequeues returned data, %0d hit an empty queue; peak occupancy %0d of %0d.",
             deq_done, deq_on_empty, peak_in_use, sbmq_pkg::SLOT_COUNT);
    if (error_count == 0) begin
      $display("shared_buffer_multi_queue_tb: done, clean");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("shared_buffer_multi_queue_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", expected_results.size());
    $display("shared_buffer_multi_queue_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sbmq_pkg.sv
design/sbmq_front.sv
design/sbmq_back.sv
design/shared_buffer_multi_queue.sv
tb/shared_buffer_multi_queue_tb.sv
